>>> sv/eoi_pkg.sv
`default_nettype none
package eoi_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CNT_W = 5;
  localparam int MAC_LAST = 31;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [15:0] STEP_TIME_RST = 16'd655;
  localparam logic [23:0] STEP_RATE_RST = 24'd25600;

  typedef enum logic [7:0] {
    REG_OFFSET_X  = 8'd0,
    REG_OFFSET_Y  = 8'd1,
    REG_STEP_TIME = 8'd2,
    REG_STEP_RATE = 8'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORD,
    ST_FLIP,
    ST_MAC,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    A_C,
    A_S,
    A_WX,
    A_WY,
    A_DX,
    A_DY
  } a_sel_t;

  typedef enum logic [2:0] {
    B_VX,
    B_VY,
    B_OX,
    B_OY,
    B_ST,
    B_SR
  } b_sel_t;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_WX,
    WR_WY,
    WR_SPX,
    WR_SPY,
    WR_NX,
    WR_NY,
    WR_VX,
    WR_VY
  } store_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   hi;
    logic   neg;
    logic   clr;
    store_t wr;
  } mac_op_t;

  typedef struct packed {
    logic             cap;
    logic             cord;
    logic [CNT_W-1:0] iter;
    logic             flip;
    logic             mac;
    mac_op_t          op;
    logic             load_out;
  } cmd_t;

  function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
    logic signed [32:0] v;
    unique case (i)
      5'd0:  v = 33'sd536870912;
      5'd1:  v = 33'sd316933406;
      5'd2:  v = 33'sd167458907;
      5'd3:  v = 33'sd85004756;
      5'd4:  v = 33'sd42667331;
      5'd5:  v = 33'sd21354465;
      5'd6:  v = 33'sd10679838;
      5'd7:  v = 33'sd5340245;
      5'd8:  v = 33'sd2670163;
      5'd9:  v = 33'sd1335087;
      5'd10: v = 33'sd667544;
      5'd11: v = 33'sd333772;
      5'd12: v = 33'sd166886;
      5'd13: v = 33'sd83443;
      5'd14: v = 33'sd41722;
      5'd15: v = 33'sd20861;
      5'd16: v = 33'sd10430;
      5'd17: v = 33'sd5215;
      5'd18: v = 33'sd2608;
      5'd19: v = 33'sd1304;
      5'd20: v = 33'sd652;
      5'd21: v = 33'sd326;
      5'd22: v = 33'sd163;
      5'd23: v = 33'sd81;
      5'd24: v = 33'sd41;
      5'd25: v = 33'sd20;
      5'd26: v = 33'sd10;
      5'd27: v = 33'sd5;
      5'd28: v = 33'sd3;
      5'd29: v = 33'sd1;
      5'd30: v = 33'sd1;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

  function automatic mac_op_t mk_op(input a_sel_t a, input b_sel_t b, input logic hi,
                                    input logic neg, input logic clr);
    mac_op_t o;
    o.a_sel = a;
    o.b_sel = b;
    o.hi = hi;
    o.neg = neg;
    o.clr = clr;
    o.wr = WR_NONE;
    return o;
  endfunction

  function automatic mac_op_t mk_wr(input store_t w);
    mac_op_t o;
    o = mk_op(A_C, B_VX, 1'b0, 1'b0, 1'b0);
    o.wr = w;
    return o;
  endfunction

  function automatic mac_op_t mac_op(input logic [CNT_W-1:0] k);
    mac_op_t o;
    unique case (k)
      5'd0:  o = mk_op(A_C, B_VX, 1'b0, 1'b0, 1'b1);
      5'd1:  o = mk_op(A_C, B_VX, 1'b1, 1'b0, 1'b0);
      5'd2:  o = mk_op(A_S, B_VY, 1'b0, 1'b1, 1'b0);
      5'd3:  o = mk_op(A_S, B_VY, 1'b1, 1'b1, 1'b0);
      5'd4:  o = mk_wr(WR_WX);
      5'd5:  o = mk_op(A_S, B_VX, 1'b0, 1'b0, 1'b1);
      5'd6:  o = mk_op(A_S, B_VX, 1'b1, 1'b0, 1'b0);
      5'd7:  o = mk_op(A_C, B_VY, 1'b0, 1'b0, 1'b0);
      5'd8:  o = mk_op(A_C, B_VY, 1'b1, 1'b0, 1'b0);
      5'd9:  o = mk_wr(WR_WY);
      5'd10: o = mk_op(A_WX, B_ST, 1'b0, 1'b0, 1'b1);
      5'd11: o = mk_op(A_WX, B_ST, 1'b1, 1'b0, 1'b0);
      5'd12: o = mk_wr(WR_SPX);
      5'd13: o = mk_op(A_WY, B_ST, 1'b0, 1'b0, 1'b1);
      5'd14: o = mk_op(A_WY, B_ST, 1'b1, 1'b0, 1'b0);
      5'd15: o = mk_wr(WR_SPY);
      5'd16: o = mk_op(A_C, B_OX, 1'b0, 1'b0, 1'b1);
      5'd17: o = mk_op(A_C, B_OX, 1'b1, 1'b0, 1'b0);
      5'd18: o = mk_op(A_S, B_OY, 1'b0, 1'b1, 1'b0);
      5'd19: o = mk_op(A_S, B_OY, 1'b1, 1'b1, 1'b0);
      5'd20: o = mk_wr(WR_NX);
      5'd21: o = mk_op(A_S, B_OX, 1'b0, 1'b0, 1'b1);
      5'd22: o = mk_op(A_S, B_OX, 1'b1, 1'b0, 1'b0);
      5'd23: o = mk_op(A_C, B_OY, 1'b0, 1'b0, 1'b0);
      5'd24: o = mk_op(A_C, B_OY, 1'b1, 1'b0, 1'b0);
      5'd25: o = mk_wr(WR_NY);
      5'd26: o = mk_op(A_DX, B_SR, 1'b0, 1'b0, 1'b1);
      5'd27: o = mk_op(A_DX, B_SR, 1'b1, 1'b0, 1'b0);
      5'd28: o = mk_wr(WR_VX);
      5'd29: o = mk_op(A_DY, B_SR, 1'b0, 1'b0, 1'b1);
      5'd30: o = mk_op(A_DY, B_SR, 1'b1, 1'b0, 1'b0);
      default: o = mk_wr(WR_VY);
    endcase
    return o;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/eoi_if.sv
`default_nettype none
interface eoi_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] yaw;
  logic signed [31:0] enc_vel_x;
  logic signed [31:0] enc_vel_y;
  modport source (output valid, operation, yaw, enc_vel_x, enc_vel_y, input ready);
  modport sink (input valid, operation, yaw, enc_vel_x, enc_vel_y, output ready);
endinterface

interface eoi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface eoi_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/encoder_odometry_integrator.sv
`default_nettype none
// Dead-reckoning odometry with a sensor mounting offset, one item at a time. A reset
// item goes from acceptance to the done state, where its result is loaded into the
// output register once the output is free; the block then returns to idle and takes
// its next item. An integration item passes through the CORDIC iterations, then the
// quadrant correction, then the steps on the single shared 35 x 18 bit multiply-
// accumulate unit, which forms every wide product as two partial products and gives
// each rounded store a step of its own, and then reaches the done state to load the
// result. A stalled output holds an item that waits to load in the done state.
// A finished result waits in the output register while the next item is accepted.
// Configuration writes are always ready and take effect at once.
module encoder_odometry_integrator #(
  parameter int CORDIC_STEPS = eoi_pkg::CORDIC_STEPS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  eoi_in_if.sink   in_ch,
  eoi_out_if.source out_ch,
  eoi_cfg_if.sink  cfg_ch
);

  eoi_pkg::cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  eoi_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_op(in_ch.operation),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd(cmd)
  );

  eoi_datapath u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .in_operation(in_ch.operation),
    .in_yaw(in_ch.yaw),
    .in_enc_vel_x(in_ch.enc_vel_x),
    .in_enc_vel_y(in_ch.enc_vel_y),
    .cfg_we(cfg_ch.valid),
    .cfg_index(cfg_ch.index),
    .cfg_data(cfg_ch.data),
    .pos_x(out_ch.pos_x),
    .pos_y(out_ch.pos_y),
    .vel_x(out_ch.vel_x),
    .vel_y(out_ch.vel_y)
  );

endmodule
`default_nettype wire

>>> sv/eoi_ctrl.sv
`default_nettype none
module eoi_ctrl #(
  parameter int CORDIC_STEPS = eoi_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output eoi_pkg::cmd_t      cmd
);

  localparam int CW = eoi_pkg::CNT_W;

  eoi_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      eoi_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = in_op ? eoi_pkg::ST_DONE : eoi_pkg::ST_CORD;
        end
      end
      eoi_pkg::ST_CORD: begin
        if (cnt_r == CW'(CORDIC_STEPS - 1)) begin
          state_nxt = eoi_pkg::ST_FLIP;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      eoi_pkg::ST_FLIP: begin
        state_nxt = eoi_pkg::ST_MAC;
        cnt_nxt = '0;
      end
      eoi_pkg::ST_MAC: begin
        if (cnt_r == CW'(eoi_pkg::MAC_LAST)) begin
          state_nxt = eoi_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      eoi_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = eoi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = eoi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    cmd.iter = cnt_r;
    cmd.op = eoi_pkg::mac_op(cnt_r);
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      eoi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.cap = in_valid;
      end
      eoi_pkg::ST_CORD: cmd.cord = 1'b1;
      eoi_pkg::ST_FLIP: cmd.flip = 1'b1;
      eoi_pkg::ST_MAC:  cmd.mac = 1'b1;
      eoi_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eoi_pkg::ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/eoi_datapath.sv
`default_nettype none
module eoi_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire eoi_pkg::cmd_t      cmd,
  input  wire logic               in_operation,
  input  wire logic signed [15:0] in_yaw,
  input  wire logic signed [31:0] in_enc_vel_x,
  input  wire logic signed [31:0] in_enc_vel_y,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      vel_x,
  output logic signed [31:0]      vel_y
);

  logic signed [23:0] offx_r, offy_r;
  logic [15:0]        st_r;
  logic [23:0]        sr_r;
  logic signed [31:0] vx_r, vy_r;
  logic               flip_r;
  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic signed [65:0] acc_r;
  logic signed [33:0] wx_r, wy_r;
  logic signed [31:0] spx_r, spy_r, nx_r, ny_r, bpx_r, bpy_r, bvx_r, bvy_r;
  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;

  logic signed [33:0] dx, dy;
  logic signed [32:0] ang;
  logic signed [34:0] a_val;
  logic signed [32:0] b_val;
  logic signed [17:0] b_part;
  logic signed [52:0] prod;
  logic signed [65:0] prod_x, term;
  logic signed [65:0] acc_nxt;
  logic signed [35:0] r30;
  logic signed [49:0] r16;
  logic signed [57:0] r8;
  logic signed [65:0] sum_tmp;
  logic               yaw_flip;

  assign yaw_flip = in_yaw[15] ^ in_yaw[14];
  assign dx = y_r >>> cmd.iter;
  assign dy = x_r >>> cmd.iter;
  assign ang = eoi_pkg::atan_q30(cmd.iter[4:0]);

  always_comb begin
    unique case (cmd.op.a_sel)
      eoi_pkg::A_C:  a_val = 35'(x_r);
      eoi_pkg::A_S:  a_val = 35'(y_r);
      eoi_pkg::A_WX: a_val = 35'(wx_r);
      eoi_pkg::A_WY: a_val = 35'(wy_r);
      eoi_pkg::A_DX: a_val = 35'(nx_r) - 35'(bpx_r);
      eoi_pkg::A_DY: a_val = 35'(ny_r) - 35'(bpy_r);
      default:       a_val = '0;
    endcase
    unique case (cmd.op.b_sel)
      eoi_pkg::B_VX: b_val = 33'(vx_r);
      eoi_pkg::B_VY: b_val = 33'(vy_r);
      eoi_pkg::B_OX: b_val = 33'(offx_r);
      eoi_pkg::B_OY: b_val = 33'(offy_r);
      eoi_pkg::B_ST: b_val = {17'd0, st_r};
      eoi_pkg::B_SR: b_val = {9'd0, sr_r};
      default:       b_val = '0;
    endcase
    b_part = cmd.op.hi ? {{2{b_val[32]}}, b_val[32:17]} : {1'b0, b_val[16:0]};
    prod = a_val * b_part;
    prod_x = 66'(prod);
    term = cmd.op.hi ? {prod_x[48:0], 17'd0} : prod_x;
    if (cmd.op.neg) begin
      term = -term;
    end
    acc_nxt = cmd.op.clr ? term : acc_r + term;
    sum_tmp = acc_r + 66'sd536870912;
    r30 = sum_tmp[65:30];
    sum_tmp = acc_r + 66'sd32768;
    r16 = sum_tmp[65:16];
    sum_tmp = acc_r + 66'sd128;
    r8 = sum_tmp[65:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offx_r <= '0;
      offy_r <= '0;
      st_r <= eoi_pkg::STEP_TIME_RST;
      sr_r <= eoi_pkg::STEP_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eoi_pkg::REG_OFFSET_X:  offx_r <= cfg_data;
        eoi_pkg::REG_OFFSET_Y:  offy_r <= cfg_data;
        eoi_pkg::REG_STEP_TIME: st_r <= cfg_data[15:0];
        eoi_pkg::REG_STEP_RATE: sr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      vx_r <= in_enc_vel_x;
      vy_r <= in_enc_vel_y;
      flip_r <= yaw_flip;
      x_r <= eoi_pkg::CORDIC_GAIN;
      y_r <= '0;
      z_r <= 33'($signed({in_yaw[14], in_yaw[14:0], 16'd0}));
    end else if (cmd.cord) begin
      if (!z_r[32]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end
    end else if (cmd.flip && flip_r) begin
      x_r <= -x_r;
      y_r <= -y_r;
    end
    if (cmd.mac && cmd.op.wr == eoi_pkg::WR_NONE) begin
      acc_r <= acc_nxt;
    end
    if (cmd.mac) begin
      unique case (cmd.op.wr)
        eoi_pkg::WR_WX: wx_r <= r30[33:0];
        eoi_pkg::WR_WY: wy_r <= r30[33:0];
        eoi_pkg::WR_NX: nx_r <= eoi_pkg::sat32(66'(spx_r) - 66'(r30));
        eoi_pkg::WR_NY: ny_r <= eoi_pkg::sat32(66'(spy_r) - 66'(r30));
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      pos_x_r <= bpx_r;
      pos_y_r <= bpy_r;
      vel_x_r <= bvx_r;
      vel_y_r <= bvy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spx_r <= '0;
      spy_r <= '0;
      bpx_r <= '0;
      bpy_r <= '0;
      bvx_r <= '0;
      bvy_r <= '0;
    end else if (cmd.cap && in_operation) begin
      spx_r <= 32'(offx_r);
      spy_r <= 32'(offy_r);
      bpx_r <= '0;
      bpy_r <= '0;
      bvx_r <= '0;
      bvy_r <= '0;
    end else if (cmd.mac) begin
      unique case (cmd.op.wr)
        eoi_pkg::WR_SPX: spx_r <= eoi_pkg::sat32(66'(spx_r) + 66'(r16));
        eoi_pkg::WR_SPY: spy_r <= eoi_pkg::sat32(66'(spy_r) + 66'(r16));
        eoi_pkg::WR_VX: begin
          bvx_r <= eoi_pkg::sat32(66'(r8));
          bpx_r <= nx_r;
        end
        eoi_pkg::WR_VY: begin
          bvy_r <= eoi_pkg::sat32(66'(r8));
          bpy_r <= ny_r;
        end
        default: ;
      endcase
    end
  end

  assign pos_x = pos_x_r;
  assign pos_y = pos_y_r;
  assign vel_x = vel_x_r;
  assign vel_y = vel_y_r;

endmodule
`default_nettype wire

>>> sv/eoi_checker.sv
`default_nettype none
module eoi_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] pos_x,
  input wire logic [31:0] vel_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pos_x) && $stable(vel_x))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind encoder_odometry_integrator eoi_checker u_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .pos_x(out_ch.pos_x),
  .vel_x(out_ch.vel_x)
);
`default_nettype wire
